// ----- rtl/register_alu_with_nzcv_flags_unit_defines.svh -----
// Assertion macros for the register ALU with NZCV flags.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef REGISTER_ALU_WITH_NZCV_FLAGS_UNIT_DEFINES_SVH
`define REGISTER_ALU_WITH_NZCV_FLAGS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RNZ_CHECK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed: lbl");
`define RNZ_CHECK_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed: lbl");
`else
`define RNZ_CHECK_IMP(lbl, clk, rst_n, ante, cons)
`define RNZ_CHECK_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rnz_pkg.sv -----
// Shared types and constants for the register ALU with NZCV flags.
// Used by every module of the block; depends on nothing.
package rnz_pkg;

    localparam int REG_COUNT_DEF  = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int IDX_W          = 3;
    localparam int IMM_W          = 32;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_AND = 3'd1,
        OP_LSR = 3'd2,
        OP_LSL = 3'd3,
        OP_ORR = 3'd4,
        OP_SUB = 3'd5,
        OP_XOR = 3'd6,
        OP_MOV = 3'd7
    } t_op;

    // A decoded instruction as it travels from the front end to the execute side.
    typedef struct packed {
        t_op              op;
        logic             set_flags;
        logic             upd_cv;
        logic [IDX_W-1:0] dest_reg;
        logic             a_is_imm;
        logic [IDX_W-1:0] a_reg;
        logic [IMM_W-1:0] a_imm;
        logic             b_is_imm;
        logic [IDX_W-1:0] b_reg;
        logic [IMM_W-1:0] b_imm;
    } t_instr;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

endpackage

// ----- rtl/rnz_front.sv -----
// Front end: takes instruction words from the input channel and classifies them.
// Depends on rnz_pkg; feeds rnz_queue.
module rnz_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_operation,
    input  logic                     i_set_flags,
    input  logic [rnz_pkg::IDX_W-1:0] i_dest_reg,
    input  logic                     i_a_is_imm,
    input  logic [rnz_pkg::IDX_W-1:0] i_a_reg,
    input  logic [rnz_pkg::IMM_W-1:0] i_a_imm,
    input  logic                     i_b_is_imm,
    input  logic [rnz_pkg::IDX_W-1:0] i_b_reg,
    input  logic [rnz_pkg::IMM_W-1:0] i_b_imm,
    output logic                     o_dec_valid,
    input  logic                     i_dec_ready,
    output rnz_pkg::t_instr          o_dec_instr
);

    logic            r_vld;
    rnz_pkg::t_instr r_instr;
    rnz_pkg::t_instr n_instr;
    logic            take;

    assign o_in_ready = !r_vld || i_dec_ready;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_instr           = '0;
        n_instr.op        = rnz_pkg::t_op'(i_operation);
        n_instr.set_flags = i_set_flags;
        // Only the arithmetic operations produce fresh carry and overflow.
        n_instr.upd_cv    = (n_instr.op == rnz_pkg::OP_ADD) || (n_instr.op == rnz_pkg::OP_SUB);
        n_instr.dest_reg  = i_dest_reg;
        n_instr.a_is_imm  = i_a_is_imm;
        n_instr.a_reg     = i_a_reg;
        n_instr.a_imm     = i_a_imm;
        n_instr.b_is_imm  = i_b_is_imm;
        n_instr.b_reg     = i_b_reg;
        n_instr.b_imm     = i_b_imm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_dec_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_instr <= n_instr;
        end
    end

    assign o_dec_valid = r_vld;
    assign o_dec_instr = r_instr;

endmodule

// ----- rtl/rnz_queue.sv -----
// Short instruction queue that decouples the front end from the execute side.
// Depends on rnz_pkg for the instruction type and its depth.
module rnz_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  rnz_pkg::t_instr i_push_instr,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output rnz_pkg::t_instr o_pop_instr
);

    localparam int DEPTH = rnz_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rnz_pkg::t_instr r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_instr  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_instr;
        end
    end

endmodule

// ----- rtl/rnz_back.sv -----
// Execute side: register file read stage, ALU, flags and the result register.
// Depends on rnz_pkg and the assertion macros header.
`include "register_alu_with_nzcv_flags_unit_defines.svh"
module rnz_back #(
    parameter int REG_COUNT  = rnz_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rnz_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ins_valid,
    output logic                      o_ins_ready,
    input  rnz_pkg::t_instr           i_ins,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [rnz_pkg::IDX_W-1:0] o_written_reg,
    output logic [DATA_WIDTH-1:0]     o_result,
    output rnz_pkg::t_flags           o_flags
);

    localparam int AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int SHW = $clog2(DATA_WIDTH);

    // Register file storage; an entry not yet written reads as zero.
    logic [DATA_WIDTH-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  r_valid;

    logic                  r_a_vld;
    rnz_pkg::t_instr       r_a_ins;
    logic [DATA_WIDTH-1:0] r_a_rda;
    logic [DATA_WIDTH-1:0] r_a_rdb;

    logic                      r_out_vld;
    logic [rnz_pkg::IDX_W-1:0] r_out_dst;
    logic [DATA_WIDTH-1:0]     r_out_res;
    rnz_pkg::t_flags           r_flags;
    rnz_pkg::t_flags           n_flags;

    logic                  out_free;
    logic                  exec;
    logic                  load;
    logic                  we;
    logic [AW-1:0]         w_addr;
    logic [AW-1:0]         ra_addr;
    logic [AW-1:0]         rb_addr;
    logic [DATA_WIDTH-1:0] opa;
    logic [DATA_WIDTH-1:0] opb;
    logic [DATA_WIDTH-1:0] opb_x;
    logic [DATA_WIDTH:0]   sum;
    logic                  is_sub;
    logic                  big_shift;
    logic [DATA_WIDTH-1:0] res;
    logic                  cout;
    logic                  ovf;

    function automatic logic in_range(input logic [rnz_pkg::IDX_W-1:0] idx);
        return 5'(idx) < 5'(REG_COUNT);
    endfunction

    assign out_free    = !r_out_vld || i_out_ready;
    assign exec        = r_a_vld && out_free;
    assign load        = i_ins_valid && (!r_a_vld || exec);
    assign o_ins_ready = !r_a_vld || exec;

    assign we      = exec && in_range(r_a_ins.dest_reg);
    assign w_addr  = AW'(r_a_ins.dest_reg);
    assign ra_addr = AW'(i_ins.a_reg);
    assign rb_addr = AW'(i_ins.b_reg);

    // ALU on the instruction held in the read stage.
    always_comb begin
        opa       = r_a_ins.a_is_imm ? DATA_WIDTH'(r_a_ins.a_imm) : r_a_rda;
        opb       = r_a_ins.b_is_imm ? DATA_WIDTH'(r_a_ins.b_imm) : r_a_rdb;
        is_sub    = (r_a_ins.op == rnz_pkg::OP_SUB);
        // Subtraction is A plus inverted B plus one, so carry out means no borrow.
        opb_x     = is_sub ? ~opb : opb;
        sum       = {1'b0, opa} + {1'b0, opb_x} + {{DATA_WIDTH{1'b0}}, is_sub};
        cout      = sum[DATA_WIDTH];
        ovf       = (opa[DATA_WIDTH-1] == opb_x[DATA_WIDTH-1]) &&
                    (sum[DATA_WIDTH-1] != opa[DATA_WIDTH-1]);
        big_shift = (opb >= DATA_WIDTH'(DATA_WIDTH));
        res       = '0;
        unique case (r_a_ins.op)
            rnz_pkg::OP_ADD: res = sum[DATA_WIDTH-1:0];
            rnz_pkg::OP_SUB: res = sum[DATA_WIDTH-1:0];
            rnz_pkg::OP_AND: res = opa & opb;
            rnz_pkg::OP_ORR: res = opa | opb;
            rnz_pkg::OP_XOR: res = opa ^ opb;
            rnz_pkg::OP_LSR: res = big_shift ? '0 : (opa >> opb[SHW-1:0]);
            rnz_pkg::OP_LSL: res = big_shift ? '0 : (opa << opb[SHW-1:0]);
            rnz_pkg::OP_MOV: res = opa;
        endcase
    end

    always_comb begin
        n_flags = r_flags;
        if (exec && r_a_ins.set_flags) begin
            n_flags.n = res[DATA_WIDTH-1];
            n_flags.z = (res == '0);
            if (r_a_ins.upd_cv) begin
                n_flags.c = cout;
                n_flags.v = ovf;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
            r_valid   <= '0;
        end else begin
            if (load) begin
                r_a_vld <= 1'b1;
            end else if (exec) begin
                r_a_vld <= 1'b0;
            end
            if (exec) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            r_flags <= n_flags;
            if (we) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[w_addr] <= res;
        end
    end

    // Read stage: registered reads with the write of the executing word
    // passed straight through, so a dependent word sees it at once.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a_ins <= i_ins;
            if (!in_range(i_ins.a_reg)) begin
                r_a_rda <= '0;
            end else if (we && (w_addr == ra_addr)) begin
                r_a_rda <= res;
            end else if (!r_valid[ra_addr]) begin
                r_a_rda <= '0;
            end else begin
                r_a_rda <= r_mem[ra_addr];
            end
            if (!in_range(i_ins.b_reg)) begin
                r_a_rdb <= '0;
            end else if (we && (w_addr == rb_addr)) begin
                r_a_rdb <= res;
            end else if (!r_valid[rb_addr]) begin
                r_a_rdb <= '0;
            end else begin
                r_a_rdb <= r_mem[rb_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_dst <= r_a_ins.dest_reg;
            r_out_res <= res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_written_reg = r_out_dst;
    assign o_result      = r_out_res;
    assign o_flags       = r_flags;

    `RNZ_CHECK_NXT(a_flags_kept, i_clk, i_rst_n, exec && !r_a_ins.set_flags, $stable(r_flags))
    `RNZ_CHECK_NXT(a_nz_match, i_clk, i_rst_n, exec && r_a_ins.set_flags, (r_flags.z == (r_out_res == '0)) && (r_flags.n == r_out_res[DATA_WIDTH-1]))
    `RNZ_CHECK_NXT(a_cv_kept, i_clk, i_rst_n, exec && r_a_ins.set_flags && !r_a_ins.upd_cv, (r_flags.c == $past(r_flags.c)) && (r_flags.v == $past(r_flags.v)))
    `RNZ_CHECK_IMP(a_stall_cause, i_clk, i_rst_n, r_a_vld && !exec, r_out_vld && !i_out_ready)

endmodule

// ----- rtl/register_alu_with_nzcv_flags_unit.sv -----
// Top level of the register ALU with NZCV flags.
// Depends on rnz_pkg, rnz_front, rnz_queue and rnz_back.
//
//   Channel | Handshake               | Word
//   --------+-------------------------+-----------------------------------------------
//   in      | i_in_valid / o_in_ready | operation, set_flags, dest_reg, operands
//   out     | o_out_valid/i_out_ready | written_reg, result_value, flag_n/z/c/v
//
// One instruction per clock is sustained while the output is taken; a word accepted
// at the input passes the input register, the queue, the register file read stage
// and the result register before it is valid at the output.
// A dependent instruction can follow directly: the register file write is passed
// through to the read stage in the same cycle.
// Reset clears the register file valid bits and the flags, so all registers read zero.
// A stalled output holds the execute side; the two-entry queue lets the front end
// keep accepting until it fills.
module register_alu_with_nzcv_flags_unit #(
    parameter int REG_COUNT  = rnz_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = rnz_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic        i_set_flags,
    input  logic [2:0]  i_dest_reg,
    input  logic        i_a_is_imm,
    input  logic [2:0]  i_a_reg,
    input  logic [31:0] i_a_imm,
    input  logic        i_b_is_imm,
    input  logic [2:0]  i_b_reg,
    input  logic [31:0] i_b_imm,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_written_reg,
    output logic [31:0] o_result_value,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_c,
    output logic        o_flag_v
);

    logic                  dec_valid;
    logic                  dec_ready;
    rnz_pkg::t_instr       dec_instr;
    logic                  q_valid;
    logic                  q_ready;
    rnz_pkg::t_instr       q_instr;
    logic [DATA_WIDTH-1:0] result;
    rnz_pkg::t_flags       flags;

    rnz_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_set_flags (i_set_flags),
        .i_dest_reg  (i_dest_reg),
        .i_a_is_imm  (i_a_is_imm),
        .i_a_reg     (i_a_reg),
        .i_a_imm     (i_a_imm),
        .i_b_is_imm  (i_b_is_imm),
        .i_b_reg     (i_b_reg),
        .i_b_imm     (i_b_imm),
        .o_dec_valid (dec_valid),
        .i_dec_ready (dec_ready),
        .o_dec_instr (dec_instr)
    );

    rnz_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (dec_valid),
        .o_push_ready (dec_ready),
        .i_push_instr (dec_instr),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_instr  (q_instr)
    );

    rnz_back #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ins_valid   (q_valid),
        .o_ins_ready   (q_ready),
        .i_ins         (q_instr),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_written_reg (o_written_reg),
        .o_result      (result),
        .o_flags       (flags)
    );

    assign o_result_value = 32'(result);
    assign o_flag_n       = flags.n;
    assign o_flag_z       = flags.z;
    assign o_flag_c       = flags.c;
    assign o_flag_v       = flags.v;

endmodule
